// ===== src/twrq_pkg.sv =====
// twrq_pkg: shared types and constants of the timestamp window ring queue
// no dependencies

package twrq_pkg;

	localparam int unsigned TS_W        = 32;
	localparam int unsigned OUT_W       = 10;
	localparam logic [TS_W-1:0] WINDOW_RESET = 32'd27000;
	localparam logic [OUT_W-1:0] OUT_MAX     = 10'd1023;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic [OUT_W-1:0] slot_index;
		logic             pop_empty;
		logic [OUT_W-1:0] head_slot;
		logic [OUT_W-1:0] tail_slot;
		logic [OUT_W-1:0] used_count;
		logic [OUT_W-1:0] dropped_count;
	} result_t;

endpackage

// ===== src/twrq_ram.sv =====
// twrq_ram: generic single write port, single read port ram
// registered read data, valid in the cycle after the address; no dependencies

module twrq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/twrq_ctrl.sv =====
// twrq_ctrl: head/tail sequencer with push, pop and one-per-cycle age trim
// uses twrq_pkg and the timestamp memory twrq_ram

module twrq_ctrl #(
	parameter int unsigned QUEUE_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        mode,
	input  logic [twrq_pkg::TS_W-1:0]   packet_timestamp,
	input  logic [twrq_pkg::TS_W-1:0]   trim_window,
	output logic                        busy,
	output logic                        res_valid,
	input  logic                        res_ready,
	output twrq_pkg::result_t           res
);

	localparam int unsigned PTR_W = $clog2(QUEUE_SLOTS);
	localparam int unsigned EXT_W = PTR_W + twrq_pkg::OUT_W;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                state_q;
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic [PTR_W-1:0]          used_q;
	logic [PTR_W-1:0]          drop_q;
	logic                      mode_q;
	logic                      empty_q;
	logic [twrq_pkg::TS_W-1:0] ts_q;

	logic [PTR_W-1:0]          head_nxt;
	logic [PTR_W-1:0]          tail_nxt;
	logic [PTR_W-1:0]          raddr;
	logic [twrq_pkg::TS_W-1:0] rdata;
	logic [twrq_pkg::TS_W-1:0] age;
	logic                      full;
	logic                      ram_we;

	assign head_nxt = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign full     = (tail_nxt == head_q);
	assign ram_we   = (state_q == ST_IDLE) && start && (mode == twrq_pkg::MODE_PUSH);
	assign raddr    = (state_q == ST_CMP) ? head_nxt : head_q;
	assign age      = ts_q - rdata;

	twrq_ram #(
		.WIDTH (twrq_pkg::TS_W),
		.DEPTH (QUEUE_SLOTS)
	) u_ts_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (packet_timestamp),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			used_q  <= '0;
			drop_q  <= '0;
			mode_q  <= twrq_pkg::MODE_PUSH;
			empty_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						empty_q <= 1'b0;
						drop_q  <= '0;
						if (mode == twrq_pkg::MODE_PUSH) begin
							tail_q <= tail_nxt;
							if (full) begin
								head_q <= head_nxt;
								drop_q <= PTR_W'(1);
							end else begin
								used_q <= used_q + 1'b1;
							end
							// trim only when at least two remain after the push
							if ((trim_window != '0) &&
							    ((full && (used_q > PTR_W'(1))) ||
							     (!full && (used_q != '0)))) begin
								state_q <= ST_READ;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							if (used_q == '0) begin
								empty_q <= 1'b1;
							end else begin
								head_q <= head_nxt;
								used_q <= used_q - 1'b1;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (age > trim_window) begin
						head_q <= head_nxt;
						used_q <= used_q - 1'b1;
						drop_q <= drop_q + 1'b1;
						if (used_q <= PTR_W'(2)) begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			ts_q <= packet_timestamp;
		end
	end

	logic [EXT_W-1:0] head_ext;
	logic [EXT_W-1:0] tail_ext;
	logic [EXT_W-1:0] used_ext;
	logic [EXT_W-1:0] drop_ext;

	assign head_ext = {{twrq_pkg::OUT_W{1'b0}}, head_q};
	assign tail_ext = {{twrq_pkg::OUT_W{1'b0}}, tail_q};
	assign used_ext = {{twrq_pkg::OUT_W{1'b0}}, used_q};
	assign drop_ext = {{twrq_pkg::OUT_W{1'b0}}, drop_q};

	always_comb begin
		res.pop_empty = empty_q;
		res.head_slot = head_ext[twrq_pkg::OUT_W-1:0];
		res.tail_slot = tail_ext[twrq_pkg::OUT_W-1:0];
		if (mode_q == twrq_pkg::MODE_PUSH) begin
			res.slot_index = tail_ext[twrq_pkg::OUT_W-1:0];
		end else if (empty_q) begin
			res.slot_index = '0;
		end else begin
			res.slot_index = head_ext[twrq_pkg::OUT_W-1:0];
		end
		res.used_count = (used_ext > EXT_W'(twrq_pkg::OUT_MAX)) ?
			twrq_pkg::OUT_MAX : used_ext[twrq_pkg::OUT_W-1:0];
		res.dropped_count = (drop_ext > EXT_W'(twrq_pkg::OUT_MAX)) ?
			twrq_pkg::OUT_MAX : drop_ext[twrq_pkg::OUT_W-1:0];
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

endmodule

// ===== src/timestamp_window_ring_queue.sv =====
// channel  dir  handshake              word
// in       in   in_valid / in_stall    mode, packet_timestamp
// out      out  out_valid / out_stall  slot_index, pop_empty, head_slot, tail_slot,
//                                      used_count, dropped_count
// cfg      in   cfg_valid / cfg_ready  cfg_data (trim_window)
//
// pop and push without trim go from accept straight to the done state; push with trim
// passes the read state, then repeats the compare state once per trimmed entry until
// an entry is within the window or one is left, one timestamp ram read per head step
// one word at a time; next word accepted while a result waits in the output register
// reset: pointers and counts cleared, trim_window 27000, ram contents not cleared
// out_stall holds the result; sequencer waits in its last state if output is full
// top level: twrq_ctrl, twrq_ram, twrq_pkg

module timestamp_window_ring_queue #(
	parameter int unsigned QUEUE_SLOTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [twrq_pkg::TS_W-1:0]    packet_timestamp,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [twrq_pkg::OUT_W-1:0]   slot_index,
	output logic                         pop_empty,
	output logic [twrq_pkg::OUT_W-1:0]   head_slot,
	output logic [twrq_pkg::OUT_W-1:0]   tail_slot,
	output logic [twrq_pkg::OUT_W-1:0]   used_count,
	output logic [twrq_pkg::OUT_W-1:0]   dropped_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [twrq_pkg::TS_W-1:0]    cfg_data
);

	logic [twrq_pkg::TS_W-1:0] window_q;
	logic                      busy;
	logic                      res_valid;
	logic                      res_ready;
	twrq_pkg::result_t         res;
	twrq_pkg::result_t         res_q;
	logic                      out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= twrq_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	twrq_ctrl #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (in_valid),
		.mode             (mode),
		.packet_timestamp (packet_timestamp),
		.trim_window      (window_q),
		.busy             (busy),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res              (res)
	);

	assign in_stall  = busy;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_index    = res_q.slot_index;
	assign pop_empty     = res_q.pop_empty;
	assign head_slot     = res_q.head_slot;
	assign tail_slot     = res_q.tail_slot;
	assign used_count    = res_q.used_count;
	assign dropped_count = res_q.dropped_count;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer did not go busy after accepting a word");

	a_empty_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pop_empty |-> (used_count == '0) && (dropped_count == '0) &&
			(slot_index == '0) && (head_slot == tail_slot))
		else $error("empty pop result carries changed state");

	a_zero_used_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (used_count == '0) |-> head_slot == tail_slot)
		else $error("empty ring with head and tail apart");

	a_push_slot_is_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pop_empty && (used_count != '0) && (dropped_count != '0) |->
			slot_index == tail_slot)
		else $error("drops reported on a result whose slot is not the tail");

endmodule
